// ===== sv/dblp_pkg.sv =====
// Shared types and constants for the decimal byte literal parser.
`timescale 1ns / 1ps

package dblp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 8;

    // Magnitude limit checked before each multiply by the base.
    localparam logic [VALUE_W-1:0] DEC_BASE    = 8'd10;
    localparam logic [VALUE_W-1:0] ACC_LIMIT   = 8'd12;
    localparam logic [VALUE_W-1:0] POS_MAX_MAG = 8'd127;
    localparam logic [VALUE_W-1:0] NEG_MAX_MAG = 8'd128;
    localparam logic [VALUE_W-1:0] ACC_MAX     = 8'd129;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_TRAIL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    typedef struct packed {
        phase_t              phase;
        logic                negative;
        logic [VALUE_W-1:0]  acc;
        status_t             err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:    PH_LEAD,
        negative: 1'b0,
        acc:      '0,
        err:      ST_OK
    };

endpackage

// ===== sv/dblp_step.sv =====
// Per-character parse step: next state and the result on a last character.
`timescale 1ns / 1ps

module dblp_step
    import dblp_pkg::*;
(
    input  parse_state_t        cur,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic                last_char,
    output parse_state_t        nxt,
    output logic [VALUE_W-1:0]  value,
    output status_t             status
);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    logic               is_digit;
    logic               blank;
    logic [CHAR_W-1:0]  digit_val;
    logic               acc_over;
    logic [VALUE_W-1:0] acc_grown;
    parse_state_t       upd;
    parse_state_t       dig;

    assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign blank     = is_blank(char_code);
    assign digit_val = char_code - CH_ZERO;
    assign acc_over  = cur.acc > ACC_LIMIT;
    // acc is at most 12 here, so acc * 10 + 9 stays within 8 bits
    assign acc_grown = VALUE_W'(cur.acc * DEC_BASE) + digit_val;

    // Digit taken: either grow the magnitude or flag out of range.
    always_comb
    begin
        dig = cur;
        if (acc_over)
        begin
            dig.err = ST_RANGE;
        end
        else
        begin
            dig.acc   = acc_grown;
            dig.phase = PH_DIGIT;
        end
    end

    always_comb
    begin
        upd = cur;
        if (cur.err == ST_OK)
        begin
            unique case (cur.phase)
                PH_LEAD:
                begin
                    priority if (blank)
                        upd = cur;
                    else if (char_code == CH_MINUS)
                    begin
                        upd.negative = 1'b1;
                        upd.phase    = PH_SIGN;
                    end
                    else if (char_code == CH_PLUS)
                        upd.phase = PH_SIGN;
                    else if (is_digit)
                        upd = dig;
                    else
                        upd.err = ST_MALFORMED;
                end
                PH_SIGN:
                begin
                    if (is_digit)
                        upd = dig;
                    else
                        upd.err = ST_MALFORMED;
                end
                PH_DIGIT:
                begin
                    priority if (is_digit)
                        upd = dig;
                    else if (blank)
                        upd.phase = PH_TRAIL;
                    else
                        upd.err = ST_MALFORMED;
                end
                PH_TRAIL:
                begin
                    if (!blank)
                        upd.err = ST_MALFORMED;
                end
                default:
                begin
                    upd = cur;
                end
            endcase
        end
    end

    // Final check on the updated state; drop back to start after a last char.
    always_comb
    begin
        status = upd.err;
        value  = '0;
        if (upd.err == ST_OK)
        begin
            priority if ((upd.phase == PH_LEAD) || (upd.phase == PH_SIGN))
                status = ST_MALFORMED;
            else if (upd.negative)
            begin
                if (upd.acc > NEG_MAX_MAG)
                    status = ST_RANGE;
                else
                    value = VALUE_W'(0) - upd.acc;
            end
            else
            begin
                if (upd.acc > POS_MAX_MAG)
                    status = ST_RANGE;
                else
                    value = upd.acc;
            end
        end
        nxt = last_char ? STATE_RESET : upd;
    end

endmodule

// ===== sv/decimal_byte_literal_parser.sv =====
// Top level of the signed decimal byte literal parser (stream in, stream out).
`timescale 1ns / 1ps
// Path: an accepted character passes from the input register through the parse
//   step; a last character's result loads into the result register.
// Throughput: one character per cycle, except that a last character waits
//   in the input register while an unread result holds the result register.
// Reset: rst_n clears the parse state to the leading white space phase and
//   empties both registers.

module decimal_byte_literal_parser
    import dblp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // slave side: one character per request
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] char_code
    input  logic               s_axis_tlast,   // last_char
    // master side: one result per literal
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [7:0] value (signed)
    output logic [1:0]         m_axis_tuser    // [1:0] status
);

    // Input register: holds one accepted character request.
    logic               in_valid_reg;
    logic [CHAR_W-1:0]  in_char_reg;
    logic               in_last_reg;

    // Parse state, advanced once per character leaving the input register.
    parse_state_t       state_reg;
    parse_state_t       state_next;

    // Result register.
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    status_t            out_status_reg;

    logic               step_value_unused_guard;
    logic [VALUE_W-1:0] step_value;
    status_t            step_status;

    logic               out_free;
    logic               advance;
    logic               s_accept;

    // The result slot is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;
    // A non-last character never needs the result slot, so it always advances.
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign step_value_unused_guard = 1'b0;

    dblp_step u_step (
        .cur       (state_reg),
        .char_code (in_char_reg),
        .last_char (in_last_reg),
        .nxt       (state_next),
        .value     (step_value),
        .status    (step_status)
    );

    // Control state: valid flags and parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;

            // Load a result on a last character, otherwise drop it once taken.
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= step_value_unused_guard;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_value_reg  <= step_value;
            out_status_reg <= step_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

`ifndef SYNTHESIS
    // An error result always carries a zero value.
    a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero value");

    // The magnitude never passes the one-step overflow bound.
    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.acc <= ACC_MAX)
        else $error("accumulator above bound");

    // Before any digit the magnitude is still zero.
    a_acc_zero_before_digit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg.phase == PH_LEAD) || (state_reg.phase == PH_SIGN))
        |-> (state_reg.acc == '0))
        else $error("nonzero accumulator before first digit");

    // A last character waits in the input register while the result is stalled.
    a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg && m_axis_tvalid && !m_axis_tready)
        |=> (in_valid_reg && $stable(state_reg)))
        else $error("last character advanced into a full result register");
`endif

endmodule
